// File: hw/rtl/hrhc_pkg.sv
// Package for the HTTP response header checker.
// Holds the transfer payload types, the line phase enum and shared constants.
// No dependencies.
package hrhc_pkg;

	// Default width of the saturating header line counters
	localparam int COUNT_WIDTH_DEF = 16;

	// Widths of the result fields
	localparam int VERSION_W = 4;
	localparam int CODE_W    = 10;
	localparam int HCOUNT_W  = 16;

	// Character codes
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_COLON = 8'd58;

	// Status line layout: "HTTP/1." then digit, ws, three digits, ws
	localparam logic [3:0] POS_VERSION  = 4'd7;
	localparam logic [3:0] POS_WS_A     = 4'd8;
	localparam logic [3:0] POS_CODE_LO  = 4'd9;
	localparam logic [3:0] POS_CODE_HI  = 4'd11;
	localparam logic [3:0] POS_WS_B     = 4'd12;
	localparam logic [3:0] STATUS_MIN   = 4'd13;
	localparam logic [3:0] POS_MAX      = 4'd15;

	// "HTTP/1." indexed by position, byte 0 in the low bits
	localparam logic [55:0] STATUS_PREFIX = 56'h2E_31_2F_50_54_54_48;

	// Line phase
	typedef enum logic [1:0] {
		PH_STATUS = 2'd0,
		PH_HEADER = 2'd1,
		PH_FAILED = 2'd2
	} phase_t;

	// One input transfer
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} hdr_item_t;

	// One summary result transfer
	typedef struct packed {
		logic                status_line_present;
		logic                status_line_valid;
		logic [VERSION_W-1:0] minor_version;
		logic [CODE_W-1:0]    status_code;
		logic [HCOUNT_W-1:0]  valid_headers;
		logic [HCOUNT_W-1:0]  invalid_headers;
	} res_item_t;

	// Expected prefix byte at a position below seven
	function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
		prefix_byte = STATUS_PREFIX[{idx, 3'b000} +: 8];
	endfunction

endpackage

// File: hw/rtl/hrhc_line_core.sv
// Per-byte line state and counters of the HTTP response header checker.
// Updates once per stepped byte and builds the summary on end of stream.
// Depends on hrhc_pkg.
module hrhc_line_core #(
	parameter int COUNT_WIDTH = hrhc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  hrhc_pkg::hdr_item_t   item,
	output hrhc_pkg::res_item_t   summary
);

	hrhc_pkg::phase_t                 phase_q, phase_d;
	logic [3:0]                       pos_q, pos_d;
	logic                             pending_q, pending_d;
	logic                             status_ok_q, status_ok_d;
	logic [hrhc_pkg::VERSION_W-1:0]   version_q, version_d;
	logic [hrhc_pkg::CODE_W-1:0]      code_q, code_d;
	logic                             colon_q, colon_d;
	logic                             key_ne_q, key_ne_d;
	logic [1:0]                       bac_q, bac_d;
	logic                             space_q, space_d;
	logic [COUNT_WIDTH-1:0]           vcnt_q, vcnt_d;
	logic [COUNT_WIDTH-1:0]           icnt_q, icnt_d;

	// Values after closing the current line
	hrhc_pkg::phase_t                 fin_phase;
	logic [COUNT_WIDTH-1:0]           fin_vcnt, fin_icnt;
	logic                             hdr_ok;
	// Values seen by the summary
	hrhc_pkg::phase_t                 eos_phase;
	logic [COUNT_WIDTH-1:0]           eos_vcnt, eos_icnt;
	logic [31:0]                      vcnt_wide, icnt_wide;

	logic [7:0] b;
	logic       b_ws;
	logic       b_digit;

	assign b       = item.data_byte;
	assign b_ws    = (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	assign b_digit = (b >= 8'd48) && (b <= 8'd57);

	// Line close: status decision or header count update
	always_comb begin
		hdr_ok    = colon_q && key_ne_q && space_q && (bac_q >= 2'd2);
		fin_phase = phase_q;
		fin_vcnt  = vcnt_q;
		fin_icnt  = icnt_q;
		unique case (phase_q)
			hrhc_pkg::PH_STATUS: begin
				fin_phase = (status_ok_q && (pos_q >= hrhc_pkg::STATUS_MIN)) ?
					hrhc_pkg::PH_HEADER : hrhc_pkg::PH_FAILED;
			end
			hrhc_pkg::PH_HEADER: begin
				if (hdr_ok) begin
					if (vcnt_q != '1) fin_vcnt = vcnt_q + 1'b1;
				end else begin
					if (icnt_q != '1) fin_icnt = icnt_q + 1'b1;
				end
			end
			hrhc_pkg::PH_FAILED: begin
			end
			default: begin
			end
		endcase
	end

	// Summary: an unfinished line is closed first
	always_comb begin
		eos_phase = pending_q ? fin_phase : phase_q;
		eos_vcnt  = pending_q ? fin_vcnt : vcnt_q;
		eos_icnt  = pending_q ? fin_icnt : icnt_q;
		vcnt_wide = 32'(eos_vcnt);
		icnt_wide = 32'(eos_icnt);

		summary.status_line_present = (eos_phase != hrhc_pkg::PH_STATUS);
		summary.status_line_valid   = (eos_phase == hrhc_pkg::PH_HEADER);
		summary.minor_version = summary.status_line_valid ? version_q : '0;
		summary.status_code   = summary.status_line_valid ? code_q : '0;
		summary.valid_headers   = (vcnt_wide > 32'h0000_FFFF) ? 16'hFFFF : vcnt_wide[15:0];
		summary.invalid_headers = (icnt_wide > 32'h0000_FFFF) ? 16'hFFFF : icnt_wide[15:0];
	end

	// Next state
	always_comb begin
		phase_d     = phase_q;
		pos_d       = pos_q;
		pending_d   = pending_q;
		status_ok_d = status_ok_q;
		version_d   = version_q;
		code_d      = code_q;
		colon_d     = colon_q;
		key_ne_d    = key_ne_q;
		bac_d       = bac_q;
		space_d     = space_q;
		vcnt_d      = vcnt_q;
		icnt_d      = icnt_q;

		if (step) begin
			if (item.end_of_stream) begin
				// back to reset after the summary
				phase_d     = hrhc_pkg::PH_STATUS;
				pos_d       = '0;
				pending_d   = 1'b0;
				status_ok_d = 1'b1;
				version_d   = '0;
				code_d      = '0;
				colon_d     = 1'b0;
				key_ne_d    = 1'b0;
				bac_d       = '0;
				space_d     = 1'b0;
				vcnt_d      = '0;
				icnt_d      = '0;
			end else if (b == hrhc_pkg::CH_LF) begin
				phase_d   = fin_phase;
				vcnt_d    = fin_vcnt;
				icnt_d    = fin_icnt;
				pos_d     = '0;
				pending_d = 1'b0;
				colon_d   = 1'b0;
				key_ne_d  = 1'b0;
				bac_d     = '0;
				space_d   = 1'b0;
			end else begin
				unique case (phase_q)
					hrhc_pkg::PH_STATUS: begin
						if (pos_q < hrhc_pkg::POS_VERSION) begin
							if (b != hrhc_pkg::prefix_byte(pos_q[2:0])) status_ok_d = 1'b0;
						end else if (pos_q == hrhc_pkg::POS_VERSION) begin
							if (b_digit) version_d = b[3:0];
							else status_ok_d = 1'b0;
						end else if ((pos_q == hrhc_pkg::POS_WS_A) ||
							(pos_q == hrhc_pkg::POS_WS_B)) begin
							if (!b_ws) status_ok_d = 1'b0;
						end else if ((pos_q >= hrhc_pkg::POS_CODE_LO) &&
							(pos_q <= hrhc_pkg::POS_CODE_HI)) begin
							// code * 10 + digit, kept to the field width
							if (b_digit) begin
								code_d = {code_q[6:0], 3'b000} + {code_q[8:0], 1'b0} +
									{6'b000000, b[3:0]};
							end else begin
								status_ok_d = 1'b0;
							end
						end
					end
					hrhc_pkg::PH_HEADER: begin
						if (!colon_q) begin
							if (b == hrhc_pkg::CH_COLON) begin
								colon_d  = 1'b1;
								key_ne_d = (pos_q != '0);
							end
						end else begin
							if (bac_q == 2'd0) space_d = b_ws;
							if (bac_q != 2'd3) bac_d = bac_q + 2'd1;
						end
					end
					hrhc_pkg::PH_FAILED: begin
					end
					default: begin
					end
				endcase
				pending_d = 1'b1;
				if (pos_q != hrhc_pkg::POS_MAX) pos_d = pos_q + 4'd1;
			end
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= hrhc_pkg::PH_STATUS;
			pos_q       <= '0;
			pending_q   <= 1'b0;
			status_ok_q <= 1'b1;
			version_q   <= '0;
			code_q      <= '0;
			colon_q     <= 1'b0;
			key_ne_q    <= 1'b0;
			bac_q       <= '0;
			space_q     <= 1'b0;
			vcnt_q      <= '0;
			icnt_q      <= '0;
		end else begin
			phase_q     <= phase_d;
			pos_q       <= pos_d;
			pending_q   <= pending_d;
			status_ok_q <= status_ok_d;
			version_q   <= version_d;
			code_q      <= code_d;
			colon_q     <= colon_d;
			key_ne_q    <= key_ne_d;
			bac_q       <= bac_d;
			space_q     <= space_d;
			vcnt_q      <= vcnt_d;
			icnt_q      <= icnt_d;
		end
	end

	// End of stream leaves the block in its reset state
	a_eos_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_of_stream |=> (phase_q == hrhc_pkg::PH_STATUS) &&
		(vcnt_q == '0) && (icnt_q == '0) && !pending_q)
		else $error("state not cleared after end of stream");

	// Bytes after the colon are only counted once a colon was seen
	a_bac_colon: assert property (@(posedge clk) disable iff (!arst_n)
		(bac_q != 2'd0) || key_ne_q |-> colon_q)
		else $error("colon tracking inconsistent");

	// Header counters move only in the header phase
	a_cnt_phase: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != hrhc_pkg::PH_HEADER |-> (vcnt_q == '0) && (icnt_q == '0))
		else $error("header count outside header phase");

endmodule

// File: hw/rtl/http_response_header_checker_unit.sv
// Top level of the HTTP response header checker.
// Input register, line state core and result register with valid/ready handshake.
// Depends on hrhc_pkg and hrhc_line_core.

// Checks an HTTP response header streamed one byte per transfer on the hdr channel.
// The first line must read "HTTP/1.", a digit, whitespace, three digits, whitespace;
// each line after a valid status line counts as a valid header when its first colon is not at the
// start, is followed by whitespace and at least one more byte. A transfer with
// end_of_stream set closes any unfinished line, yields one summary on the res
// channel and returns the block to its reset state. The block takes one byte per
// clock cycle while it is not stalled: each byte passes through an input register
// and a single state update. An end-of-stream transfer is held in the input
// register; when it steps the core, the summary is captured in the res register and
// res_valid rises. The res register lets byte transfers continue while a summary
// waits; only a second end-of-stream stalls until the first summary is taken.
module http_response_header_checker_unit #(
	parameter int COUNT_WIDTH = hrhc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 hdr_valid,
	output logic                 hdr_ready,
	input  hrhc_pkg::hdr_item_t  hdr_item,
	output logic                 res_valid,
	input  logic                 res_ready,
	output hrhc_pkg::res_item_t  res_item
);

	logic                 valid_s1;
	hrhc_pkg::hdr_item_t  item_s1;
	logic                 res_free;
	logic                 go_s1;
	hrhc_pkg::res_item_t  summary;
	hrhc_pkg::res_item_t  res_q;
	logic                 res_valid_q;

	// Stage 1 advances unless it holds an end of stream with the result slot full
	assign res_free  = !res_valid_q || res_ready;
	assign go_s1     = valid_s1 && (!item_s1.end_of_stream || res_free);
	assign hdr_ready = !valid_s1 || go_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_valid && hdr_ready) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_valid && hdr_ready) item_s1 <= hdr_item;
	end

	hrhc_line_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go_s1),
		.item    (item_s1),
		.summary (summary)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go_s1 && item_s1.end_of_stream) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && item_s1.end_of_stream) res_q <= summary;
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// A new result only follows an end-of-stream step
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(go_s1 && item_s1.end_of_stream))
		else $error("result without end of stream");

	// Backpressure only comes from a held end of stream
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!hdr_ready |-> valid_s1 && item_s1.end_of_stream && res_valid_q)
		else $error("input stalled without cause");

	// A valid status line implies one was present
	a_valid_present: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.status_line_valid |-> res_q.status_line_present)
		else $error("valid status line not marked present");

endmodule
